// ----- rtl/hashed_integrity_stack_top_assert.svh -----
// Assertion macros for the hashed integrity stack top level.
`ifndef HASHED_INTEGRITY_STACK_TOP_ASSERT_SVH
`define HASHED_INTEGRITY_STACK_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/his_pkg.sv -----
// Types, codes and hash arithmetic shared by the hashed integrity stack.
package his_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned HASH_W = 64;
	localparam int unsigned DEPTH_W = 9;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BIT_W = $clog2(VALUE_W);

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [VALUE_W-1:0] word_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP = 1'b1;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_UNDERFLOW = 2'd1;
	localparam status_t STATUS_FULL = 2'd2;

	localparam hash_t HASH_SEED = 64'h0000_0000_1603_2007;

	// Multiply by 0x01000193 modulo 2^64 as a sum of shifted copies.
	function automatic hash_t prime_mul(input hash_t h);
		prime_mul = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
	endfunction

endpackage

// ----- rtl/his_in_if.sv -----
// Request channel of the hashed integrity stack: push or pop with a value.
interface his_in_if;
	logic valid;
	logic ready;
	logic action;
	his_pkg::value_t value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

// ----- rtl/his_out_if.sv -----
// Result channel of the hashed integrity stack: status, depth, top and hash.
interface his_out_if;
	logic valid;
	logic ready;
	his_pkg::status_t status;
	his_pkg::depth_t depth;
	his_pkg::value_t top_value;
	his_pkg::hash_t content_hash;

	modport source (output valid, output status, output depth, output top_value,
		output content_hash, input ready);
	modport sink (input valid, input status, input depth, input top_value,
		input content_hash, output ready);
endinterface

// ----- rtl/hashed_integrity_stack_top.sv -----
// Hashed integrity stack: LIFO of signed words with a bitwise FNV-style content hash.
//
// Channel "in" takes one request per handshake: action 0 pushes value, action 1 pops.
// Channel "out" returns one result per request: status, depth after the request,
// the top element (0 when empty) and the hash over all held elements, bottom first.
// A successful push folds the 32 bits of the word into the hash one bit per cycle
// through a single shift-add prime multiplier in state FOLD, then passes through
// state DONE, which hands the result to the output register and returns to IDLE.
// A pop reads the saved prefix hash and the new top from the two stores, whose read
// data is registered, passing through states POP_RD, POP_WB and DONE. Underflow
// and full requests change nothing and go straight from IDLE to DONE.
// One request is in flight at a time; in.ready is high only while the sequencer idles.
// The output register holds a finished result while out.ready is low; the next
// request may be taken meanwhile, and its result waits until the register frees,
// which adds the stall cycles to that request.
// Reset clears the fill count, sets the hash to its seed and empties the output
// register. The stores are not cleared; only written entries are ever used.
module hashed_integrity_stack_top #(
	parameter int unsigned DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	his_in_if.sink in,
	his_out_if.source out
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FOLD = 3'd1;
	localparam logic [2:0] S_POP_RD = 3'd2;
	localparam logic [2:0] S_POP_WB = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [his_pkg::BIT_W-1:0] BIT_LAST = his_pkg::BIT_W'(his_pkg::VALUE_W - 1);

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	his_pkg::hash_t hash_q;
	his_pkg::value_t top_q;
	his_pkg::word_t word_q;
	logic [his_pkg::BIT_W-1:0] bit_q;
	his_pkg::status_t status_q;

	logic out_valid_q;
	his_pkg::status_t out_status_q;
	his_pkg::depth_t out_depth_q;
	his_pkg::value_t out_top_q;
	his_pkg::hash_t out_hash_q;

	his_pkg::value_t elem_mem [DEPTH];
	his_pkg::hash_t hash_mem [DEPTH];
	his_pkg::value_t rd_elem_q;
	his_pkg::hash_t rd_hash_q;

	logic in_fire;
	logic is_full;
	logic is_empty;
	logic push_ok;
	logic out_free;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] hash_rd_addr;
	logic [ADDR_W-1:0] elem_rd_addr;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W+his_pkg::DEPTH_W-1:0] cnt_wide;

	assign in.ready = (state_q == S_IDLE);
	assign in_fire = in.valid && in.ready;
	assign is_full = (cnt_q >= CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign push_ok = in_fire && (in.action == his_pkg::ACT_PUSH) && !is_full;
	assign out_free = !out_valid_q || out.ready;

	assign cnt_dec = cnt_q - CNT_W'(1);
	assign wr_addr = cnt_q[ADDR_W-1:0];
	assign hash_rd_addr = cnt_q[ADDR_W-1:0];
	assign elem_rd_addr = cnt_dec[ADDR_W-1:0];
	assign cnt_wide = {{his_pkg::DEPTH_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (push_ok) begin
			elem_mem[wr_addr] <= in.value;
			hash_mem[wr_addr] <= hash_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_hash_q <= hash_mem[hash_rd_addr];
		rd_elem_q <= elem_mem[elem_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			hash_q <= his_pkg::HASH_SEED;
			top_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in.action == his_pkg::ACT_PUSH) begin
							if (is_full) begin
								state_q <= S_DONE;
							end else begin
								top_q <= in.value;
								state_q <= S_FOLD;
							end
						end else begin
							if (is_empty) begin
								state_q <= S_DONE;
							end else begin
								cnt_q <= cnt_dec;
								state_q <= S_POP_RD;
							end
						end
					end
				end
				S_FOLD: begin
					hash_q <= his_pkg::prime_mul(hash_q ^ {{(his_pkg::HASH_W-1){1'b0}}, word_q[0]});
					if (bit_q == BIT_LAST) begin
						cnt_q <= cnt_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_WB;
				end
				S_POP_WB: begin
					hash_q <= rd_hash_q;
					top_q <= is_empty ? '0 : rd_elem_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= his_pkg::word_t'(in.value);
			bit_q <= '0;
			if (in.action == his_pkg::ACT_PUSH) begin
				status_q <= is_full ? his_pkg::STATUS_FULL : his_pkg::STATUS_OK;
			end else begin
				status_q <= is_empty ? his_pkg::STATUS_UNDERFLOW : his_pkg::STATUS_OK;
			end
		end else if (state_q == S_FOLD) begin
			word_q <= word_q >> 1;
			bit_q <= bit_q + his_pkg::BIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= status_q;
			out_depth_q <= cnt_wide[his_pkg::DEPTH_W-1:0];
			out_top_q <= top_q;
			out_hash_q <= hash_q;
		end
	end

	assign out.valid = out_valid_q;
	assign out.status = out_status_q;
	assign out.depth = out_depth_q;
	assign out.top_value = out_top_q;
	assign out.content_hash = out_hash_q;

`include "hashed_integrity_stack_top_assert.svh"

	`HIS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "fill count above depth")
	`HIS_ASSERT_NEXT(a_push_folds, push_ok, state_q == S_FOLD, "push did not start folding")
	`HIS_ASSERT_NEXT(a_fold_count, (state_q == S_FOLD) && (bit_q == BIT_LAST),
		cnt_q == $past(cnt_q) + CNT_W'(1), "fold end did not advance fill count")

endmodule

// ----- sim/hashed_integrity_stack_top_tb.sv -----
// Self-checking testbench for the hashed integrity stack: directed table, random runs, fill/drain.
module hashed_integrity_stack_top_tb;

	localparam int unsigned DEPTH = 256;
	localparam his_pkg::hash_t FOLD_MULT = 64'h0000_0000_0100_0193;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned MIXED_ITEMS = 120;
	localparam int unsigned QUIET_ITEMS = 80;
	localparam int unsigned PUSH_PCT [3] = '{50, 85, 20};
	localparam his_pkg::value_t CORNER_WORDS [4] =
		'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sh1};

	typedef struct packed {
		his_pkg::status_t status;
		his_pkg::depth_t depth;
		his_pkg::value_t top_value;
		his_pkg::hash_t content_hash;
	} stack_result_t;

	typedef struct {
		logic act;
		his_pkg::value_t val;
		bit known;
		stack_result_t res;
	} request_row_t;

	localparam stack_result_t EMPTY_OK =
		'{his_pkg::STATUS_OK, 9'd0, 32'sd0, his_pkg::HASH_SEED};
	localparam stack_result_t EMPTY_UNDERFLOW =
		'{his_pkg::STATUS_UNDERFLOW, 9'd0, 32'sd0, his_pkg::HASH_SEED};

	logic clk;
	logic arst_n;

	his_in_if in_ch();
	his_out_if out_ch();

	hashed_integrity_stack_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch)
	);

	his_pkg::value_t held_words [DEPTH];
	his_pkg::hash_t prefix_hashes [DEPTH];
	int unsigned held_count = 0;
	his_pkg::hash_t running_hash = his_pkg::HASH_SEED;

	stack_result_t expected_results [$];
	request_row_t directed_rows [$];

	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned pushes = 0;
	int unsigned pops = 0;
	int unsigned underflows = 0;
	int unsigned full_rejects = 0;
	int unsigned deepest = 0;
	int unsigned idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic his_pkg::hash_t fold_bits(input his_pkg::hash_t h,
			input his_pkg::word_t w);
		for (int b = 0; b < his_pkg::VALUE_W; b++)
			h = (h ^ his_pkg::hash_t'(w[b])) * FOLD_MULT;
		return h;
	endfunction

	function automatic stack_result_t apply_request(input logic act,
			input his_pkg::value_t val);
		stack_result_t r;
		r.status = his_pkg::STATUS_OK;
		if (act == his_pkg::ACT_PUSH) begin
			if (held_count >= DEPTH) begin
				r.status = his_pkg::STATUS_FULL;
				full_rejects++;
			end else begin
				prefix_hashes[held_count] = running_hash;
				held_words[held_count] = val;
				running_hash = fold_bits(running_hash, val);
				held_count++;
				pushes++;
			end
		end else if (held_count == 0) begin
			r.status = his_pkg::STATUS_UNDERFLOW;
			underflows++;
		end else begin
			held_count--;
			running_hash = prefix_hashes[held_count];
			pops++;
		end
		if (held_count > deepest)
			deepest = held_count;
		r.depth = his_pkg::depth_t'(held_count);
		r.top_value = (held_count != 0) ? held_words[held_count - 1] : '0;
		r.content_hash = running_hash;
		return r;
	endfunction

	function automatic his_pkg::value_t pick_word();
		if ($urandom_range(0, 7) == 0)
			return CORNER_WORDS[$urandom_range(0, 3)];
		return his_pkg::value_t'($urandom);
	endfunction

	function automatic void add_row(input logic act, input his_pkg::value_t val,
			input bit known, input stack_result_t res);
		request_row_t row;
		row.act = act;
		row.val = val;
		row.known = known;
		row.res = res;
		directed_rows.push_back(row);
	endfunction

	task automatic send_request(input logic act, input his_pkg::value_t val,
			input bit known, input stack_result_t typed);
		stack_result_t predicted;
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.value <= val;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = apply_request(act, val);
		expected_results.push_back(known ? typed : predicted);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int unsigned push_pct);
		send_request(($urandom_range(0, 99) < push_pct) ? his_pkg::ACT_PUSH : his_pkg::ACT_POP,
			pick_word(), 1'b0, '0);
	endtask

	task automatic check_result(input stack_result_t got);
		stack_result_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("unexpected result: status %0d depth %0d top %0d hash %h",
					got.status, got.depth, got.top_value, got.content_hash);
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status || got.depth !== want.depth
					|| got.top_value !== want.top_value
					|| got.content_hash !== want.content_hash) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"mismatch on result %0d: expected status %0d depth %0d top %0d ",
						"hash %h, got status %0d depth %0d top %0d hash %h"}, results_seen,
						want.status, want.depth, want.top_value, want.content_hash,
						got.status, got.depth, got.top_value, got.content_hash);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			check_result({out_ch.status, out_ch.depth, out_ch.top_value, out_ch.content_hash});
	end

	initial begin : result_sink
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
					|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[hashed_integrity_stack_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned pct;
		int unsigned burst;
		in_ch.valid = 1'b0;
		in_ch.action = his_pkg::ACT_PUSH;
		in_ch.value = '0;
		arst_n = 1'b0;

		add_row(his_pkg::ACT_POP, 32'sh0, 1'b1, EMPTY_UNDERFLOW);
		add_row(his_pkg::ACT_POP, -32'sh1, 1'b1, EMPTY_UNDERFLOW);
		add_row(his_pkg::ACT_PUSH, 32'sh7fff_ffff, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b1, EMPTY_OK);
		add_row(his_pkg::ACT_PUSH, 32'sh8000_0000, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, 32'sh0, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, -32'sh1, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, 32'sh1, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, 32'sh5555_5555, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, 32'shaaaa_aaaa, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b0, '0);
		add_row(his_pkg::ACT_POP, -32'sh1, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b1, EMPTY_OK);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b1, EMPTY_UNDERFLOW);
		add_row(his_pkg::ACT_PUSH, -32'sh1, 1'b0, '0);
		add_row(his_pkg::ACT_PUSH, -32'sh1, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh7fff_ffff, 1'b0, '0);
		add_row(his_pkg::ACT_POP, 32'sh0, 1'b1, EMPTY_OK);
		add_row(his_pkg::ACT_PUSH, 32'sh1234_5678, 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].act, directed_rows[i].val, directed_rows[i].known,
				directed_rows[i].res);

		// stall the result side while requests keep coming
		hold_request = 1'b1;
		sent = 0;
		while (sent < MIXED_ITEMS) begin
			pct = PUSH_PCT[$urandom_range(0, 2)];
			burst = $urandom_range(5, 30);
			repeat (burst) begin
				send_random(pct);
				sent++;
			end
		end

		// hold requests until every result is back
		in_ch.valid <= 1'b0;
		wait (expected_results.size() == 0);
		@(posedge clk);

		while (held_count < DEPTH)
			send_request(his_pkg::ACT_PUSH, pick_word(), 1'b0, '0);
		repeat (4) send_request(his_pkg::ACT_PUSH, pick_word(), 1'b0, '0);
		while (held_count != 0)
			send_request(his_pkg::ACT_POP, pick_word(), 1'b0, '0);
		repeat (3) send_request(his_pkg::ACT_POP, pick_word(), 1'b0, '0);

		quiet = 1'b1;
		repeat (QUIET_ITEMS) send_random(PUSH_PCT[0]);

		in_ch.valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += expected_results.size();

		$display("run covered %0d pushes, %0d pops, %0d underflows, %0d full rejects,",
			pushes, pops, underflows, full_rejects);
		$display("peak depth %0d, checked %0d results, %0d failures",
			deepest, results_seen, errors);
		if (errors == 0)
			$display("[hashed_integrity_stack_top] OK");
		else
			$display("[hashed_integrity_stack_top] ERROR");
		$finish;
	end

endmodule
